// File: rtl/kf2d_pkg.sv
// Shared types, register-file map, command codes and helpers for the 2D Kalman tracker.
`timescale 1ns / 1ps

package kf2d_pkg;

    typedef logic [6:0] addr_t;

    // Register file map (bit 6 clear): scratch and state words
    localparam addr_t A_SV   = 7'd0;   // state vector, 4 words
    localparam addr_t A_COV  = 7'd4;   // covariance, 16 words, row major
    localparam addr_t A_M    = 7'd20;  // A*P, rows 0 and 1 only
    localparam addr_t A_SP   = 7'd28;  // predicted covariance, 16 words
    localparam addr_t A_K    = 7'd44;  // gain, 4x2
    localparam addr_t A_XP   = 7'd52;  // predicted state, 4 words
    localparam addr_t A_A    = 7'd56;
    localparam addr_t A_D    = 7'd57;
    localparam addr_t A_DET  = 7'd58;
    localparam addr_t A_R0   = 7'd59;
    localparam addr_t A_R1   = 7'd60;
    localparam addr_t A_N    = 7'd61;

    // Special sources (bit 6 set): registers, request fields, constants
    localparam addr_t A_DT   = 7'h40;
    localparam addr_t A_GRAV = 7'h41;
    localparam addr_t A_PN   = 7'h42;
    localparam addr_t A_MN   = 7'h43;
    localparam addr_t A_MX   = 7'h44;
    localparam addr_t A_MY   = 7'h45;
    localparam addr_t A_IVX  = 7'h46;
    localparam addr_t A_IVY  = 7'h47;
    localparam addr_t A_IVAR = 7'h48;
    localparam addr_t A_ZERO = 7'h49;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_LDACC,
        OP_ADD,
        OP_SUB,
        OP_LDA,
        OP_MAC,
        OP_MSC,
        OP_ST,
        OP_STP,
        OP_STD,
        OP_DIV,
        OP_OUTX,
        OP_OUTY
    } op_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TIME_STEP,
        CFG_GRAVITY_INC,
        CFG_PROCESS_NOISE,
        CFG_MEAS_NOISE,
        CFG_INIT_VEL_X,
        CFG_INIT_VEL_Y,
        CFG_INIT_VARIANCE
    } cfg_idx_t;

    // Register values after reset
    localparam logic [16:0]        RST_TIME_STEP   = 17'd6554;
    localparam logic [30:0]        RST_GRAVITY_INC = 31'd64225;
    localparam logic [30:0]        RST_PROC_NOISE  = 31'd196608;
    localparam logic [30:0]        RST_MEAS_NOISE  = 31'd3276800;
    localparam logic signed [31:0] RST_INIT_VEL_X  = 32'sd6951143;
    localparam logic signed [31:0] RST_INIT_VEL_Y  = 32'sd6951143;
    localparam logic [30:0]        RST_INIT_VAR    = 31'd65536;

    // Controller to datapath
    typedef struct packed {
        logic  capture;
        logic  valid;
        op_t   op;
        addr_t addr;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic div_busy;
        logic do_init;
    } status_t;

    function automatic addr_t mat_a(input addr_t base, input logic [1:0] i,
                                    input logic [1:0] j);
        return base + addr_t'({i, j});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// File: rtl/kf2d_ctrl.sv
// Sequencer that walks the filter step through the shared datapath, one operation at a time.
`timescale 1ns / 1ps

module kf2d_ctrl
    import kf2d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output ctrl_t   ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ISSUE,
        S_GAP,
        S_DIVW0,
        S_DIVW,
        S_FIN
    } state_t;

    typedef enum logic [3:0] {
        PH_INIT,
        PH_PRED,
        PH_M,
        PH_SP,
        PH_S,
        PH_K,
        PH_R,
        PH_X,
        PH_P,
        PH_OUT
    } phase_t;

    typedef struct packed {
        op_t   op;
        addr_t addr;
        logic  last;
    } step_t;

    state_t      state_reg;
    phase_t      phase_reg;
    logic [4:0]  elem_reg;
    logic [3:0]  step_reg;
    logic        done_reg;
    logic        out_valid_reg;
    step_t       cur;
    logic        hold;

    function automatic step_t mk(input op_t op, input addr_t ad, input logic last);
        step_t r;
        r.op   = op;
        r.addr = ad;
        r.last = last;
        return r;
    endfunction

    // A*P row selector: rows 0 and 1 come from scratch, rows 2 and 3 equal P
    function automatic addr_t mrow(input logic [1:0] i, input logic [1:0] k);
        if (i[1])
            return mat_a(A_COV, i, k);
        else
            return A_M + addr_t'({i[0], k});
    endfunction

    function automatic logic [4:0] elem_last(input phase_t ph);
        case (ph)
            PH_INIT: return 5'd19;
            PH_PRED: return 5'd3;
            PH_M:    return 5'd7;
            PH_SP:   return 5'd15;
            PH_S:    return 5'd2;
            PH_K:    return 5'd7;
            PH_R:    return 5'd1;
            PH_X:    return 5'd3;
            PH_P:    return 5'd15;
            default: return 5'd0;
        endcase
    endfunction

    function automatic phase_t next_phase(input phase_t ph);
        case (ph)
            PH_INIT: return PH_PRED;
            PH_PRED: return PH_M;
            PH_M:    return PH_SP;
            PH_SP:   return PH_S;
            PH_S:    return PH_K;
            PH_K:    return PH_R;
            PH_R:    return PH_X;
            PH_X:    return PH_P;
            default: return PH_OUT;
        endcase
    endfunction

    // Operation list of each matrix element
    function automatic step_t step_f(input phase_t ph, input logic [4:0] e,
                                     input logic [3:0] s);
        logic [1:0] i;
        logic [1:0] j;
        logic [3:0] idx;
        logic       diag;
        step_t      r;
        i    = e[3:2];
        j    = e[1:0];
        idx  = e[3:0] - 4'd4;
        diag = (i == j);
        r    = mk(OP_LDACC, A_ZERO, 1'b1);
        case (ph)
            PH_INIT: begin
                if (e < 5'd4) begin
                    case (s)
                        4'd0:    r = mk(OP_LDACC, e[1] ? (e[0] ? A_IVY : A_IVX) : A_ZERO,
                                        1'b0);
                        default: r = mk(OP_ST, A_SV + addr_t'(e[1:0]), 1'b1);
                    endcase
                end else begin
                    case (s)
                        4'd0:    r = mk(OP_LDACC, (idx[3:2] == idx[1:0]) ? A_IVAR : A_ZERO,
                                        1'b0);
                        default: r = mk(OP_ST, A_COV + addr_t'(idx), 1'b1);
                    endcase
                end
            end
            PH_PRED: begin
                if (!e[1]) begin
                    case (s)
                        4'd0:    r = mk(OP_LDACC, A_SV + addr_t'(e[1:0]), 1'b0);
                        4'd1:    r = mk(OP_LDA, A_DT, 1'b0);
                        4'd2:    r = mk(OP_MAC, A_SV + addr_t'(e[1:0]) + 7'd2, 1'b0);
                        default: r = mk(OP_ST, A_XP + addr_t'(e[1:0]), 1'b1);
                    endcase
                end else if (!e[0]) begin
                    case (s)
                        4'd0:    r = mk(OP_LDACC, A_SV + 7'd2, 1'b0);
                        default: r = mk(OP_ST, A_XP + 7'd2, 1'b1);
                    endcase
                end else begin
                    case (s)
                        4'd0:    r = mk(OP_LDACC, A_SV + 7'd3, 1'b0);
                        4'd1:    r = mk(OP_SUB, A_GRAV, 1'b0);
                        default: r = mk(OP_ST, A_XP + 7'd3, 1'b1);
                    endcase
                end
            end
            PH_M: begin
                case (s)
                    4'd0:    r = mk(OP_LDACC, mat_a(A_COV, {1'b0, e[2]}, j), 1'b0);
                    4'd1:    r = mk(OP_LDA, A_DT, 1'b0);
                    4'd2:    r = mk(OP_MAC, mat_a(A_COV, {1'b1, e[2]}, j), 1'b0);
                    default: r = mk(OP_ST, A_M + addr_t'({e[2], j}), 1'b1);
                endcase
            end
            PH_SP: begin
                if (!j[1]) begin
                    case (s)
                        4'd0:    r = mk(OP_LDACC, mrow(i, j), 1'b0);
                        4'd1:    r = mk(OP_LDA, A_DT, 1'b0);
                        4'd2:    r = mk(OP_MAC, mrow(i, {1'b1, j[0]}), 1'b0);
                        4'd3:    r = mk(OP_ST, mat_a(A_SP, i, j), !diag);
                        4'd4:    r = mk(OP_LDACC, mat_a(A_SP, i, j), 1'b0);
                        4'd5:    r = mk(OP_ADD, A_PN, 1'b0);
                        default: r = mk(OP_STP, mat_a(A_SP, i, j), 1'b1);
                    endcase
                end else if (!diag) begin
                    case (s)
                        4'd0:    r = mk(OP_LDACC, mrow(i, j), 1'b0);
                        default: r = mk(OP_ST, mat_a(A_SP, i, j), 1'b1);
                    endcase
                end else begin
                    case (s)
                        4'd0:    r = mk(OP_LDACC, mrow(i, j), 1'b0);
                        4'd1:    r = mk(OP_ADD, A_PN, 1'b0);
                        default: r = mk(OP_STP, mat_a(A_SP, i, j), 1'b1);
                    endcase
                end
            end
            PH_S: begin
                if (e[1]) begin
                    // determinant of the innovation matrix
                    case (s)
                        4'd0:    r = mk(OP_LDACC, A_ZERO, 1'b0);
                        4'd1:    r = mk(OP_LDA, A_A, 1'b0);
                        4'd2:    r = mk(OP_MAC, A_D, 1'b0);
                        4'd3:    r = mk(OP_LDA, mat_a(A_SP, 2'd0, 2'd1), 1'b0);
                        4'd4:    r = mk(OP_MSC, mat_a(A_SP, 2'd1, 2'd0), 1'b0);
                        default: r = mk(OP_STD, A_DET, 1'b1);
                    endcase
                end else begin
                    case (s)
                        4'd0:    r = mk(OP_LDACC, mat_a(A_SP, {1'b0, e[0]}, {1'b0, e[0]}),
                                        1'b0);
                        4'd1:    r = mk(OP_ADD, A_MN, 1'b0);
                        default: r = mk(OP_ST, e[0] ? A_D : A_A, 1'b1);
                    endcase
                end
            end
            PH_K: begin
                case (s)
                    4'd0:    r = mk(OP_LDACC, A_ZERO, 1'b0);
                    4'd1:    r = mk(OP_LDA, mat_a(A_SP, e[2:1], {1'b0, e[0]}), 1'b0);
                    4'd2:    r = mk(OP_MAC, e[0] ? A_A : A_D, 1'b0);
                    4'd3:    r = mk(OP_LDA, mat_a(A_SP, e[2:1], {1'b0, !e[0]}), 1'b0);
                    4'd4:    r = mk(OP_MSC, e[0] ? mat_a(A_SP, 2'd0, 2'd1)
                                                 : mat_a(A_SP, 2'd1, 2'd0), 1'b0);
                    4'd5:    r = mk(OP_ST, A_N, 1'b0);
                    4'd6:    r = mk(OP_LDA, A_N, 1'b0);
                    4'd7:    r = mk(OP_DIV, A_DET, 1'b0);
                    default: r = mk(OP_ST, A_K + addr_t'(e[2:0]), 1'b1);
                endcase
            end
            PH_R: begin
                case (s)
                    4'd0:    r = mk(OP_LDACC, e[0] ? A_MY : A_MX, 1'b0);
                    4'd1:    r = mk(OP_SUB, A_XP + addr_t'(e[0]), 1'b0);
                    default: r = mk(OP_ST, e[0] ? A_R1 : A_R0, 1'b1);
                endcase
            end
            PH_X: begin
                case (s)
                    4'd0:    r = mk(OP_LDACC, A_XP + addr_t'(j), 1'b0);
                    4'd1:    r = mk(OP_LDA, A_K + addr_t'({j, 1'b0}), 1'b0);
                    4'd2:    r = mk(OP_MAC, A_R0, 1'b0);
                    4'd3:    r = mk(OP_LDA, A_K + addr_t'({j, 1'b1}), 1'b0);
                    4'd4:    r = mk(OP_MAC, A_R1, 1'b0);
                    default: r = mk(OP_ST, A_SV + addr_t'(j), 1'b1);
                endcase
            end
            PH_P: begin
                case (s)
                    4'd0:    r = mk(OP_LDACC, mat_a(A_SP, i, j), 1'b0);
                    4'd1:    r = mk(OP_LDA, A_K + addr_t'({i, 1'b0}), 1'b0);
                    4'd2:    r = mk(OP_MSC, mat_a(A_SP, 2'd0, j), 1'b0);
                    4'd3:    r = mk(OP_LDA, A_K + addr_t'({i, 1'b1}), 1'b0);
                    4'd4:    r = mk(OP_MSC, mat_a(A_SP, 2'd1, j), 1'b0);
                    default: r = mk(diag ? OP_STP : OP_ST, mat_a(A_COV, i, j), 1'b1);
                endcase
            end
            default: begin
                case (s)
                    4'd0:    r = mk(OP_OUTX, A_SV, 1'b0);
                    default: r = mk(OP_OUTY, A_SV + 7'd1, 1'b1);
                endcase
            end
        endcase
        return r;
    endfunction

    assign cur  = step_f(phase_reg, elem_reg, step_reg);
    // output registers are reused only once the previous result is taken
    assign hold = (phase_reg == PH_OUT) && (step_reg == 4'd0) && out_valid_reg;

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign ctrl.capture = (state_reg == S_IDLE) && in_valid;
    assign ctrl.valid   = (state_reg == S_ISSUE) && !hold;
    assign ctrl.op      = cur.op;
    assign ctrl.addr    = cur.addr;

    // Sequencer state and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_INIT;
            elem_reg      <= '0;
            step_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid)
                        state_reg <= S_START;
                end
                S_START: begin
                    phase_reg <= status.do_init ? PH_INIT : PH_PRED;
                    elem_reg  <= '0;
                    step_reg  <= '0;
                    done_reg  <= 1'b0;
                    state_reg <= S_ISSUE;
                end
                S_ISSUE: begin
                    if (!hold)
                    begin
                        if (cur.last)
                        begin
                            step_reg <= '0;
                            if (elem_reg == elem_last(phase_reg))
                            begin
                                elem_reg <= '0;
                                if (phase_reg == PH_OUT)
                                    done_reg <= 1'b1;
                                else
                                    phase_reg <= next_phase(phase_reg);
                            end
                            else
                                elem_reg <= elem_reg + 5'd1;
                        end
                        else
                            step_reg <= step_reg + 4'd1;
                        state_reg <= (cur.op == OP_DIV) ? S_DIVW0 : S_GAP;
                    end
                end
                S_GAP: begin
                    state_reg <= done_reg ? S_FIN : S_ISSUE;
                end
                S_DIVW0: begin
                    state_reg <= S_DIVW;
                end
                S_DIVW: begin
                    if (!status.div_busy)
                        state_reg <= S_ISSUE;
                end
                S_FIN: begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/kf2d_datapath.sv
// Register file, shared multiply-accumulate, serial divider and configuration registers.
`timescale 1ns / 1ps

module kf2d_datapath
    import kf2d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    output status_t            status,
    input  logic signed [31:0] meas_x,
    input  logic signed [31:0] meas_y,
    input  logic               restart,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic signed [31:0] est_x,
    output logic signed [31:0] est_y
);

    localparam int DW = 33 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    // configuration
    logic [16:0]        ts_reg;
    logic [30:0]        grav_reg;
    logic [30:0]        pn_reg;
    logic [30:0]        mn_reg;
    logic signed [31:0] ivx_reg;
    logic signed [31:0] ivy_reg;
    logic [30:0]        ivar_reg;

    // request capture
    logic signed [31:0] mx_reg;
    logic signed [31:0] my_reg;
    logic               use_cfg_reg;
    logic               do_init_reg;
    logic               init_pend_reg;

    // register file and execute stage
    logic [31:0]        mem [64];
    logic [31:0]        mem_q;
    logic               ex_reg;
    op_t                op1_reg;
    addr_t              addr1_reg;
    logic signed [31:0] opa_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic               mac_pend_reg;
    logic               mac_sub_reg;
    logic signed [31:0] est_x_reg;
    logic signed [31:0] est_y_reg;

    // divider
    logic               busy_reg;
    logic [CW-1:0]      cnt_reg;
    logic [31:0]        den_reg;
    logic [31:0]        rem_reg;
    logic [DW-1:0]      quo_reg;
    logic               neg_reg;

    logic signed [63:0] special;
    logic signed [63:0] src;
    logic signed [63:0] rnd;
    logic signed [31:0] sat;
    logic signed [31:0] stv;
    logic [32:0]        mag;
    logic [DW-1:0]      dividend;
    logic [32:0]        rem_s;
    logic               qbit;
    logic [32:0]        rem_d;
    logic               big;
    logic signed [31:0] div_res;
    logic               ex_mul;

    assign status.div_busy = busy_reg;
    assign status.do_init  = do_init_reg;
    assign est_x = est_x_reg;
    assign est_y = est_y_reg;

    // Source selection for the operation in execute
    always_comb
    begin
        case (addr1_reg)
            A_DT:    special = {47'd0, ts_reg};
            A_GRAV:  special = {33'd0, grav_reg};
            A_PN:    special = {33'd0, pn_reg};
            A_MN:    special = {33'd0, mn_reg};
            A_MX:    special = {{32{mx_reg[31]}}, mx_reg};
            A_MY:    special = {{32{my_reg[31]}}, my_reg};
            A_IVX:   special = use_cfg_reg ? {{32{ivx_reg[31]}}, ivx_reg}
                                           : {{32{RST_INIT_VEL_X[31]}}, RST_INIT_VEL_X};
            A_IVY:   special = use_cfg_reg ? {{32{ivy_reg[31]}}, ivy_reg}
                                           : {{32{RST_INIT_VEL_Y[31]}}, RST_INIT_VEL_Y};
            A_IVAR:  special = use_cfg_reg ? {33'd0, ivar_reg} : {33'd0, RST_INIT_VAR};
            default: special = '0;
        endcase
        src = addr1_reg[6] ? special : {{32{mem_q[31]}}, mem_q};
    end

    // Rounded product, store value and divider step
    always_comb
    begin
        rnd = (prod_reg + HALF) >>> FRAC_BITS;
        sat = sat32(acc_reg);
        case (op1_reg)
            OP_STP:  stv = sat[31] ? 32'sd0 : sat;
            OP_STD:  stv = (sat < 32'sd1) ? 32'sd1 : sat;
            default: stv = sat;
        endcase
        mag      = opa_reg[31] ? 33'(-{opa_reg[31], opa_reg}) : {1'b0, opa_reg};
        dividend = {mag, {FRAC_BITS{1'b0}}} + DW'(src[31:1]);
        rem_s    = {rem_reg, quo_reg[DW-1]};
        qbit     = (rem_s >= {1'b0, den_reg});
        rem_d    = qbit ? (rem_s - {1'b0, den_reg}) : rem_s;
        big      = |quo_reg[DW-1:31];
        if (big)
            div_res = neg_reg ? 32'sh80000000 : 32'sh7fffffff;
        else
            div_res = neg_reg ? -$signed({1'b0, quo_reg[30:0]}) : $signed({1'b0, quo_reg[30:0]});
        ex_mul = ex_reg && ((op1_reg == OP_MAC) || (op1_reg == OP_MSC));
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg   <= RST_TIME_STEP;
            grav_reg <= RST_GRAVITY_INC;
            pn_reg   <= RST_PROC_NOISE;
            mn_reg   <= RST_MEAS_NOISE;
            ivx_reg  <= RST_INIT_VEL_X;
            ivy_reg  <= RST_INIT_VEL_Y;
            ivar_reg <= RST_INIT_VAR;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TIME_STEP:     ts_reg   <= cfg_data[16:0];
                CFG_GRAVITY_INC:   grav_reg <= cfg_data[30:0];
                CFG_PROCESS_NOISE: pn_reg   <= cfg_data[30:0];
                CFG_MEAS_NOISE:    mn_reg   <= cfg_data[30:0];
                CFG_INIT_VEL_X:    ivx_reg  <= cfg_data;
                CFG_INIT_VEL_Y:    ivy_reg  <= cfg_data;
                CFG_INIT_VARIANCE: ivar_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Control: request capture, execute valid, divider sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_pend_reg <= 1'b1;
            do_init_reg   <= 1'b0;
            use_cfg_reg   <= 1'b0;
            ex_reg        <= 1'b0;
            mac_pend_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (ctrl.capture)
            begin
                do_init_reg   <= restart | init_pend_reg;
                use_cfg_reg   <= restart;
                init_pend_reg <= 1'b0;
            end
            ex_reg       <= ctrl.valid;
            mac_pend_reg <= ex_mul;
            if (ex_reg && (op1_reg == OP_DIV))
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - CW'(1);
                else
                    busy_reg <= 1'b0;
            end
        end
    end

    // Payload: operands, product, divider words, outputs
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            mx_reg <= meas_x;
            my_reg <= meas_y;
        end
        if (ctrl.valid)
        begin
            op1_reg   <= ctrl.op;
            addr1_reg <= ctrl.addr;
        end
        if (ex_reg && (op1_reg == OP_LDA))
            opa_reg <= src[31:0];
        if (ex_mul)
        begin
            prod_reg    <= opa_reg * $signed(src[31:0]);
            mac_sub_reg <= (op1_reg == OP_MSC);
        end
        if (ex_reg && (op1_reg == OP_OUTX))
            est_x_reg <= src[31:0];
        if (ex_reg && (op1_reg == OP_OUTY))
            est_y_reg <= src[31:0];
        if (ex_reg && (op1_reg == OP_DIV))
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= src[31:0];
            neg_reg <= opa_reg[31];
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= rem_d[31:0];
            quo_reg <= {quo_reg[DW-2:0], qbit};
        end
    end

    // Accumulator
    always_ff @(posedge clk)
    begin
        if (ex_reg)
        begin
            case (op1_reg)
                OP_LDACC: acc_reg <= src;
                OP_ADD:   acc_reg <= acc_reg + src;
                OP_SUB:   acc_reg <= acc_reg - src;
                default: ;
            endcase
        end
        else if (mac_pend_reg)
            acc_reg <= mac_sub_reg ? (acc_reg - rnd) : (acc_reg + rnd);
        else if (busy_reg && (cnt_reg == '0))
            acc_reg <= {{32{div_res[31]}}, div_res};
    end

    // Register file: one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
            mem_q <= mem[ctrl.addr[5:0]];
        if (ex_reg && ((op1_reg == OP_ST) || (op1_reg == OP_STP) || (op1_reg == OP_STD)))
            mem[addr1_reg[5:0]] <= stv;
    end

endmodule

// File: rtl/kalman_filter_2d_const_velocity_top.sv
// Top level of the four-state constant-velocity Kalman tracker.
`timescale 1ns / 1ps

// Tracks a projectile from 2D position measurements with a four-state filter
// (x, y, vx, vy) in signed fixed point with FRAC_BITS fraction bits, saturating
// to 32 bits. Each accepted request gives one filtered position. A single
// multiply-accumulate unit and a register file walk the prediction, gain and
// covariance update one operation at a time, 313 operations (353 on a restart
// or on the first request after reset). Eight of them are gain divisions that
// run through a bit-serial divider. The input is taken again as soon as the
// sequencer is idle; a finished result waits in its output register. The first
// request after reset loads the reset-time initial state.
module kalman_filter_2d_const_velocity_top
    import kf2d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] meas_x,
    input  logic signed [31:0] meas_y,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] est_x,
    output logic signed [31:0] est_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    ctrl_t   ctrl;
    status_t status;

    assign cfg_ready = 1'b1;

    kf2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    kf2d_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .meas_x    (meas_x),
        .meas_y    (meas_y),
        .restart   (restart),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .est_x     (est_x),
        .est_y     (est_y)
    );

endmodule

// File: rtl/kf2d_checker.sv
// Port-level checks for the Kalman tracker, bound to the top level.
`timescale 1ns / 1ps

module kf2d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] est_x,
    input logic [31:0] est_y
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(est_x) && $stable(est_y))
        else $error("result changed while stalled");

    // an accepted request keeps the block busy for its computation
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a request");

    // a result appears only at the end of a computation
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without computation");

    // a result never follows the request in the very next cycle
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result too early");

endmodule

bind kalman_filter_2d_const_velocity_top kf2d_checker u_kf2d_checker (.*);

// File: bench/kalman_filter_2d_const_velocity_top_test.sv
// Self-checking bench for the 2D constant-velocity Kalman tracker top level.
`timescale 1ns / 1ps

module kalman_filter_2d_const_velocity_top_test;
    import kf2d_pkg::*;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam int     RAND_PHASES = 6;
    localparam int     RAND_PER_PHASE = 175;
    localparam int     IDLE_LIMIT = 20000;
    localparam int     N_DIRECTED = 17;
    localparam int     N_REF_ROWS = 14;  // rows run with the reset-time registers

    typedef struct {
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic               rs;
        logic               typed;  // expected position given in the row
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } dir_row_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } est_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic               restart;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // Tracker model: registers and filter state
    logic [16:0]        dt_reg;
    logic [30:0]        grav_reg;
    logic [30:0]        pnoise_reg;
    logic [30:0]        mnoise_reg;
    logic signed [31:0] ivx_reg;
    logic signed [31:0] ivy_reg;
    logic [30:0]        ivar_reg;
    longint             track_sv[4];
    longint             track_cov[16];

    est_t est_q[$];
    int   err_cnt;
    int   sent_cnt;
    int   got_cnt;
    int   cfg_cnt;
    int   idle_cnt;
    bit   quiet;

    kalman_filter_2d_const_velocity_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .meas_x    (meas_x),
        .meas_y    (meas_y),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .est_x     (est_x),
        .est_y     (est_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic longint clip32(input longint v);
        if (v > POS_MAX)
            return POS_MAX;
        if (v < POS_MIN)
            return POS_MIN;
        return v;
    endfunction

    // Fixed-point product, rounded half up (floor of v + half)
    function automatic longint fx_mul(input longint a, input longint b);
        longint w;
        w = a * b + 64'sd32768;
        return w >>> 16;
    endfunction

    // Gain quotient, rounded half away from zero
    function automatic longint fx_div(input longint n, input longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = ((mag <<< 16) + d / 2) / d;
        if (q > POS_MAX + 1)
            q = POS_MAX + 1;
        return clip32((n < 0) ? -q : q);
    endfunction

    function automatic void load_track();
        track_sv[0] = 0;
        track_sv[1] = 0;
        track_sv[2] = ivx_reg;
        track_sv[3] = ivy_reg;
        for (int i = 0; i < 16; i++)
            track_cov[i] = 0;
        for (int i = 0; i < 4; i++)
            track_cov[i * 5] = longint'(ivar_reg);
    endfunction

    // One filter step: predict, gain, correct, covariance update
    function automatic est_t track_step(input longint mx, input longint my, input bit rs);
        longint xp[4];
        longint m[16];
        longint sp[16];
        longint k[8];
        longint dtl, a, b, c, d, det, r0, r1, h0, h1, n0, n1, v;
        est_t   e;
        if (rs)
            load_track();
        dtl = longint'(dt_reg);
        xp[0] = clip32(track_sv[0] + fx_mul(dtl, track_sv[2]));
        xp[1] = clip32(track_sv[1] + fx_mul(dtl, track_sv[3]));
        xp[2] = track_sv[2];
        xp[3] = clip32(track_sv[3] - longint'(grav_reg));
        for (int j = 0; j < 4; j++)
        begin
            m[j]      = clip32(track_cov[j] + fx_mul(dtl, track_cov[8 + j]));
            m[4 + j]  = clip32(track_cov[4 + j] + fx_mul(dtl, track_cov[12 + j]));
            m[8 + j]  = track_cov[8 + j];
            m[12 + j] = track_cov[12 + j];
        end
        for (int i = 0; i < 4; i++)
        begin
            sp[i * 4]     = clip32(m[i * 4] + fx_mul(dtl, m[i * 4 + 2]));
            sp[i * 4 + 1] = clip32(m[i * 4 + 1] + fx_mul(dtl, m[i * 4 + 3]));
            sp[i * 4 + 2] = m[i * 4 + 2];
            sp[i * 4 + 3] = m[i * 4 + 3];
        end
        // process noise on the diagonal, negative variance clamped
        for (int i = 0; i < 4; i++)
        begin
            v = clip32(sp[i * 5] + longint'(pnoise_reg));
            sp[i * 5] = (v < 0) ? 0 : v;
        end
        a = clip32(sp[0] + longint'(mnoise_reg));
        b = sp[1];
        c = sp[4];
        d = clip32(sp[5] + longint'(mnoise_reg));
        det = clip32(fx_mul(a, d) - fx_mul(b, c));
        if (det < 1)
            det = 1;
        for (int i = 0; i < 4; i++)
        begin
            h0 = sp[i * 4];
            h1 = sp[i * 4 + 1];
            n0 = clip32(fx_mul(h0, d) - fx_mul(h1, c));
            n1 = clip32(fx_mul(h1, a) - fx_mul(h0, b));
            k[i * 2]     = fx_div(n0, det);
            k[i * 2 + 1] = fx_div(n1, det);
        end
        r0 = clip32(mx - xp[0]);
        r1 = clip32(my - xp[1]);
        for (int i = 0; i < 4; i++)
            track_sv[i] = clip32(xp[i] + fx_mul(k[i * 2], r0) + fx_mul(k[i * 2 + 1], r1));
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                track_cov[i * 4 + j] = clip32(sp[i * 4 + j] - fx_mul(k[i * 2], sp[j])
                                              - fx_mul(k[i * 2 + 1], sp[4 + j]));
        for (int i = 0; i < 4; i++)
            if (track_cov[i * 5] < 0)
                track_cov[i * 5] = 0;
        e.x = track_sv[0][31:0];
        e.y = track_sv[1][31:0];
        return e;
    endfunction

    task automatic report(input string what, input logic signed [31:0] got,
                          input logic signed [31:0] want);
        err_cnt++;
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, got_cnt);
    endtask

    // Register write, mirrored into the model
    task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_cnt++;
        case (idx)
            CFG_TIME_STEP:     dt_reg     = data[16:0];
            CFG_GRAVITY_INC:   grav_reg   = data[30:0];
            CFG_PROCESS_NOISE: pnoise_reg = data[30:0];
            CFG_MEAS_NOISE:    mnoise_reg = data[30:0];
            CFG_INIT_VEL_X:    ivx_reg    = data;
            CFG_INIT_VEL_Y:    ivy_reg    = data;
            CFG_INIT_VARIANCE: ivar_reg   = data[30:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic cfg_all(input logic [31:0] v0, input logic [31:0] v1,
                           input logic [31:0] v2, input logic [31:0] v3,
                           input logic [31:0] v4, input logic [31:0] v5,
                           input logic [31:0] v6);
        cfg_write(CFG_TIME_STEP, v0);
        cfg_write(CFG_GRAVITY_INC, v1);
        cfg_write(CFG_PROCESS_NOISE, v2);
        cfg_write(CFG_MEAS_NOISE, v3);
        cfg_write(CFG_INIT_VEL_X, v4);
        cfg_write(CFG_INIT_VEL_Y, v5);
        cfg_write(CFG_INIT_VARIANCE, v6);
    endtask

    // Wait until every pending estimate has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (est_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Send one measurement request; the expected estimate is queued on acceptance
    task automatic send_meas(input logic signed [31:0] mx, input logic signed [31:0] my,
                             input logic rs, input logic typed,
                             input logic signed [31:0] ex, input logic signed [31:0] ey);
        int   gap;
        est_t e;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        meas_x   <= mx;
        meas_y   <= my;
        restart  <= rs;
        do
            @(posedge clk);
        while (in_stall);
        e = track_step(longint'(mx), longint'(my), rs);
        if (typed)
        begin
            e.x = ex;
            e.y = ey;
        end
        est_q.push_back(e);
        sent_cnt++;
    endtask

    // Random register set, with values past the stated ranges at times
    task automatic cfg_random();
        cfg_all($urandom_range(0, 131071), $urandom_range(0, 2000000), $urandom_range(0, 4000000),
                $urandom_range(0, 50000000), $urandom, $urandom, $urandom_range(0, 8000000));
    endtask

    // Result side: random stall per result
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 4);
            out_stall <= (n != 0);
            do
                @(posedge clk);
            while (!out_valid);
            if (n != 0)
            begin
                repeat (n - 1) @(posedge clk);
                out_stall <= 1'b0;
                do
                    @(posedge clk);
                while (!out_valid);
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        est_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (est_q.size() == 0)
                report("unexpected est_x", est_x, 32'sd0);
            else
            begin
                w = est_q.pop_front();
                if (est_x !== w.x)
                    report("est_x", est_x, w.x);
                if (est_y !== w.y)
                    report("est_y", est_y, w.y);
            end
            got_cnt++;
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT)
        begin
            $display("timeout with %0d estimates pending", est_q.size());
            $display("kalman_filter_2d_const_velocity_top verification failed");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_tab[N_DIRECTED];
        longint   nx, ny;
        int       pick;

        // Directed rows: the reset-time registers first, then a zero-gain setup
        dir_tab[0]  = '{32'sd0, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'sd0};
        dir_tab[1]  = '{32'sd65536, -32'sd65536, 1'b0, 1'b0, 32'sd0, 32'sd0};
        dir_tab[2]  = '{32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b0, 32'sd0, 32'sd0};
        dir_tab[3]  = '{32'sh80000000, 32'sh80000000, 1'b0, 1'b0, 32'sd0, 32'sd0};
        dir_tab[4]  = '{32'sh7fffffff, 32'sh80000000, 1'b1, 1'b0, 32'sd0, 32'sd0};
        dir_tab[5]  = '{32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0, 32'sd0, 32'sd0};
        dir_tab[6]  = '{-32'sd1, 32'sd1, 1'b1, 1'b0, 32'sd0, 32'sd0};
        dir_tab[7]  = '{32'sh55555555, 32'shaaaaaaaa, 1'b0, 1'b0, 32'sd0, 32'sd0};
        dir_tab[8]  = '{32'shaaaaaaaa, 32'sh55555555, 1'b1, 1'b0, 32'sd0, 32'sd0};
        dir_tab[9]  = '{32'sd700000, 32'sd650000, 1'b0, 1'b0, 32'sd0, 32'sd0};
        dir_tab[10] = '{32'sd1400000, 32'sd1250000, 1'b0, 1'b0, 32'sd0, 32'sd0};
        dir_tab[11] = '{32'sd2100000, 32'sd1800000, 1'b0, 1'b0, 32'sd0, 32'sd0};
        dir_tab[12] = '{32'sd0, 32'sd0, 1'b1, 1'b0, 32'sd0, 32'sd0};
        dir_tab[13] = '{32'sd700000, 32'sd700000, 1'b0, 1'b0, 32'sd0, 32'sd0};
        // zero gain: no variance and a pivot below one LSB, estimate stays at zero
        dir_tab[14] = '{32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b1, 32'sd0, 32'sd0};
        dir_tab[15] = '{32'sh80000000, 32'sh80000000, 1'b0, 1'b1, 32'sd0, 32'sd0};
        dir_tab[16] = '{32'sh12345678, -32'sd1, 1'b0, 1'b1, 32'sd0, 32'sd0};

        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        meas_x = '0;
        meas_y = '0;
        restart = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        err_cnt = 0;
        sent_cnt = 0;
        got_cnt = 0;
        cfg_cnt = 0;
        idle_cnt = 0;
        quiet = 1'b0;
        dt_reg = RST_TIME_STEP;
        grav_reg = RST_GRAVITY_INC;
        pnoise_reg = RST_PROC_NOISE;
        mnoise_reg = RST_MEAS_NOISE;
        ivx_reg = RST_INIT_VEL_X;
        ivy_reg = RST_INIT_VEL_Y;
        ivar_reg = RST_INIT_VAR;
        load_track();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            if (r == N_REF_ROWS)
            begin
                drain();
                cfg_all(32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0);
            end
            send_meas(dir_tab[r].mx, dir_tab[r].my, dir_tab[r].rs, dir_tab[r].typed,
                      dir_tab[r].ex, dir_tab[r].ey);
        end

        // Random phases, each under its own register set
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            case (ph)
                0: cfg_all(32'(RST_TIME_STEP), 32'(RST_GRAVITY_INC), 32'(RST_PROC_NOISE),
                           32'(RST_MEAS_NOISE), RST_INIT_VEL_X, RST_INIT_VEL_Y,
                           32'(RST_INIT_VAR));
                1: cfg_random();
                2: cfg_all(32'h1ffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff, 32'h80000000, 32'h7fffffff);
                3: cfg_all(32'd0, 32'd0, 32'd0, 32'd0, 32'h80000000, 32'h7fffffff, 32'd0);
                4: cfg_random();
                default: cfg_all(32'd65536, 32'd1, 32'd1, 32'd1, 32'hffffffff, 32'd1, 32'd1);
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                quiet = ((n / 40) % 3) == 2;
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    send_meas($urandom, $urandom, $urandom_range(0, 1), 1'b0, 32'sd0, 32'sd0);
                else
                begin
                    // measurement near the current track, small noise
                    nx = clip32(track_sv[0] + $signed($urandom_range(0, 524288)) - 262144);
                    ny = clip32(track_sv[1] + $signed($urandom_range(0, 524288)) - 262144);
                    send_meas(nx[31:0], ny[31:0], pick < 20, 1'b0, 32'sd0, 32'sd0);
                end
            end
        end
        quiet = 1'b0;
        drain();
        repeat (100) @(posedge clk);

        $display("covered %0d measurements, %0d estimates checked, %0d register writes",
                 sent_cnt, got_cnt, cfg_cnt);
        $display("register sets: reset values, zero gain, random, both extremes");
        if (err_cnt == 0)
            $display("kalman_filter_2d_const_velocity_top verification clean");
        else
            $display("kalman_filter_2d_const_velocity_top verification failed");
        $finish;
    end

endmodule
